FILE: rtl/ttd_pkg.sv
`default_nettype none

package ttd_pkg;

    // Result event codes.
    typedef enum logic [1:0] {
        EV_ACCEPT = 2'd0,
        EV_ERROR  = 2'd1,
        EV_SAME   = 2'd2,
        EV_NEW    = 2'd3
    } t_event;

    // One received byte.
    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx;

    // One result beat.
    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  status_letter;
        logic [19:0] time_value;
    } t_res;

    // Telegram positions: idle, first digit .. last digit, check, LF, CR.
    localparam logic [3:0] POS_IDLE       = 4'd0;
    localparam logic [3:0] POS_LAST_DIGIT = 4'd6;
    localparam logic [3:0] POS_CHECK      = 4'd7;
    localparam logic [3:0] POS_LF         = 4'd8;
    localparam logic [3:0] POS_CR         = 4'd9;

    // Telegram characters.
    localparam logic [7:0] CHR_IDLE   = 8'h49;  // 'I'
    localparam logic [7:0] CHR_ARMED  = 8'h41;  // 'A'
    localparam logic [7:0] CHR_SPACE  = 8'h20;  // ' '
    localparam logic [7:0] CHR_START  = 8'h53;  // 'S'
    localparam logic [7:0] CHR_RIGHT  = 8'h52;  // 'R'
    localparam logic [7:0] CHR_LEFT   = 8'h4C;  // 'L'
    localparam logic [7:0] CHR_CANCEL = 8'h43;  // 'C'
    localparam logic [7:0] CHR_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CHR_NINE   = 8'h39;  // '9'
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_CR     = 8'h0D;

    // The check byte starts from this offset before the digits are added.
    localparam logic [6:0] CHECK_BASE = 7'd64;

    // Largest six-digit time.
    localparam logic [19:0] TIME_MAX = 20'd999999;

endpackage

`default_nettype wire

FILE: rtl/ttd_stream_if.sv
`default_nettype none

interface ttd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/timer_telegram_decoder_unit.sv
// Timer telegram decoder.
// Input channel i_rx_if carries one received serial byte per beat; the output
// channel o_res_if carries exactly one result beat for every input beat, in
// order: an event code (byte taken, decoding error, packet with the same time,
// packet with a new time) and, for a completed packet, its status letter and
// six-digit decimal time. Both channels move a beat when valid and ready are
// high at the same rising edge of i_clk.
// An input beat passes through the input register and then the result
// register, with the per-byte decoding in the single stage of logic between
// them. Throughput is one beat per cycle, sustained while the receiver takes
// every result beat; the framing state is updated as a byte moves from the
// input register into the result register.
// When the receiver stalls, the result register holds its beat, the input
// register fills with the next byte and i_rx_if.ready then drops until the
// result beat is taken; no beat is lost or repeated.
// Reset (i_rst_n low at a rising edge, synchronous) empties both registers,
// returns the framer to idle and forgets the last good packet, so the first
// good packet after reset always reports a new time.
`default_nettype none

module timer_telegram_decoder_unit (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ttd_stream_if.sink    i_rx_if,
    ttd_stream_if.source  o_res_if
);

    // Input register.
    logic             r_in_valid;
    logic [7:0]       r_in_byte;

    // Result register.
    logic             r_out_valid;
    ttd_pkg::t_res    r_out;
    ttd_pkg::t_res    n_out;

    // Framing state.
    logic [3:0]       r_position,      n_position;
    logic [6:0]       r_check_sum,     n_check_sum;
    logic [19:0]      r_time_accum,    n_time_accum;
    logic [7:0]       r_status_hold,   n_status_hold;
    logic [19:0]      r_previous_time, n_previous_time;
    logic             r_previous_valid, n_previous_valid;

    logic             w_stage_move;
    logic [7:0]       w_digit_full;
    logic [3:0]       w_digit;
    logic             w_is_digit;
    logic             w_is_status;
    logic             w_advance;
    logic [19:0]      w_time_next;

    // A byte moves into the result register when that register is empty or
    // its beat is being taken in this cycle.
    assign w_stage_move   = r_in_valid && (!r_out_valid || o_res_if.ready);
    assign i_rx_if.ready  = !r_in_valid || w_stage_move;
    assign o_res_if.valid = r_out_valid;
    assign o_res_if.payload = r_out;

    // Character classes of the byte under decode.
    assign w_digit_full = r_in_byte - ttd_pkg::CHR_ZERO;
    assign w_digit      = w_digit_full[3:0];
    assign w_is_digit   = (r_in_byte >= ttd_pkg::CHR_ZERO) &&
                          (r_in_byte <= ttd_pkg::CHR_NINE);
    assign w_is_status  = r_in_byte inside {ttd_pkg::CHR_IDLE, ttd_pkg::CHR_ARMED,
                                            ttd_pkg::CHR_SPACE, ttd_pkg::CHR_START,
                                            ttd_pkg::CHR_RIGHT, ttd_pkg::CHR_LEFT,
                                            ttd_pkg::CHR_CANCEL};

    // Times ten plus the new digit, as two shifted copies and an add.
    assign w_time_next = {r_time_accum[16:0], 3'b000} + {r_time_accum[18:0], 1'b0}
                         + {16'd0, w_digit};

    always_comb begin
        n_position       = r_position;
        n_check_sum      = r_check_sum;
        n_time_accum     = r_time_accum;
        n_status_hold    = r_status_hold;
        n_previous_time  = r_previous_time;
        n_previous_valid = r_previous_valid;
        n_out.event_res     = ttd_pkg::EV_ACCEPT;
        n_out.status_letter = 8'd0;
        n_out.time_value    = 20'd0;
        w_advance        = 1'b0;

        // Does the byte fit the current position of the telegram?
        if (r_position == ttd_pkg::POS_IDLE) begin
            w_advance = w_is_status;
            if (w_is_status) begin
                n_status_hold = r_in_byte;
                n_check_sum   = ttd_pkg::CHECK_BASE;
                n_time_accum  = 20'd0;
            end
        end else if (r_position <= ttd_pkg::POS_LAST_DIGIT) begin
            w_advance = w_is_digit;
            if (w_is_digit) begin
                n_check_sum  = r_check_sum + {3'd0, w_digit};
                n_time_accum = w_time_next;
            end
        end else if (r_position == ttd_pkg::POS_CHECK) begin
            w_advance = (r_in_byte == {1'b0, r_check_sum});
        end else if (r_position == ttd_pkg::POS_LF) begin
            w_advance = (r_in_byte == ttd_pkg::CHR_LF);
        end else if (r_position == ttd_pkg::POS_CR) begin
            w_advance = (r_in_byte == ttd_pkg::CHR_CR);
        end

        if (!w_advance) begin
            // The offending byte is dropped, even if it is a status letter.
            n_out.event_res = ttd_pkg::EV_ERROR;
            n_position      = ttd_pkg::POS_IDLE;
        end else if (r_position == ttd_pkg::POS_CR) begin
            // Packet complete: the first one after reset always counts as new.
            if (!r_previous_valid || (r_previous_time != r_time_accum)) begin
                n_previous_time = r_time_accum;
                n_out.event_res = ttd_pkg::EV_NEW;
            end else begin
                n_out.event_res = ttd_pkg::EV_SAME;
            end
            n_previous_valid    = 1'b1;
            n_out.status_letter = r_status_hold;
            n_out.time_value    = r_time_accum;
            n_position          = ttd_pkg::POS_IDLE;
        end else begin
            n_position = r_position + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_position       <= ttd_pkg::POS_IDLE;
            r_check_sum      <= 7'd0;
            r_time_accum     <= 20'd0;
            r_status_hold    <= 8'd0;
            r_previous_time  <= 20'd0;
            r_previous_valid <= 1'b0;
        end else begin
            if (i_rx_if.ready) begin
                r_in_valid <= i_rx_if.valid;
            end
            if (w_stage_move) begin
                r_out_valid      <= 1'b1;
                r_position       <= n_position;
                r_check_sum      <= n_check_sum;
                r_time_accum     <= n_time_accum;
                r_status_hold    <= n_status_hold;
                r_previous_time  <= n_previous_time;
                r_previous_valid <= n_previous_valid;
            end else if (o_res_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_rx_if.ready && i_rx_if.valid) begin
            r_in_byte <= i_rx_if.payload.rx_byte;
        end
        if (w_stage_move) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ttd_checker.sv
`default_nettype none

module ttd_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_out_valid,
    input wire logic          i_out_ready,
    input wire ttd_pkg::t_res i_out_payload
);

    logic w_packet;
    logic w_letter_ok;

    assign w_packet = (i_out_payload.event_res == ttd_pkg::EV_SAME) ||
                      (i_out_payload.event_res == ttd_pkg::EV_NEW);
    assign w_letter_ok = (i_out_payload.status_letter == ttd_pkg::CHR_IDLE)   ||
                         (i_out_payload.status_letter == ttd_pkg::CHR_ARMED)  ||
                         (i_out_payload.status_letter == ttd_pkg::CHR_SPACE)  ||
                         (i_out_payload.status_letter == ttd_pkg::CHR_START)  ||
                         (i_out_payload.status_letter == ttd_pkg::CHR_RIGHT)  ||
                         (i_out_payload.status_letter == ttd_pkg::CHR_LEFT)   ||
                         (i_out_payload.status_letter == ttd_pkg::CHR_CANCEL);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("result beat changed while stalled");

    // Only completed packets carry a letter and a time.
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !w_packet |->
            (i_out_payload.status_letter == 8'd0) && (i_out_payload.time_value == 20'd0))
        else $error("letter or time shown without a completed packet");

    // A completed packet always opened with a valid status letter.
    a_packet_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && w_packet |-> w_letter_ok)
        else $error("completed packet with a bad status letter");

    // Six decimal digits never exceed the six-digit maximum.
    a_packet_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && w_packet |-> (i_out_payload.time_value <= ttd_pkg::TIME_MAX))
        else $error("packet time out of range");

endmodule

bind timer_telegram_decoder_unit ttd_checker u_ttd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res_if.valid),
    .i_out_ready   (o_res_if.ready),
    .i_out_payload (o_res_if.payload)
);

`default_nettype wire
